// ===== rtl/bcdc_pkg.sv =====
// Package for the BCD/binary converter: widths, codes, the pipeline word type,
// the size helper functions and the per-digit add-3 helper. Depends on nothing.
package bcdc_pkg;

    localparam int NUM_BITS   = 64;
    localparam int DIGIT_BITS = 4;
    localparam int NUM_DIGITS = NUM_BITS / DIGIT_BITS;
    localparam int NUM_CELLS  = NUM_BITS;

    // Direction codes.
    localparam logic MODE_BCD2BIN = 1'b0;
    localparam logic MODE_BIN2BCD = 1'b1;

    // Operand size codes.
    typedef enum logic [1:0] {
        SIZE_BYTE  = 2'd0,
        SIZE_WORD  = 2'd1,
        SIZE_DWORD = 2'd2,
        SIZE_QWORD = 2'd3
    } t_size;

    // Largest decimal numbers that fit the digits of each size.
    localparam logic [NUM_BITS-1:0] LIMIT_BYTE  = 64'd99;
    localparam logic [NUM_BITS-1:0] LIMIT_WORD  = 64'd9999;
    localparam logic [NUM_BITS-1:0] LIMIT_DWORD = 64'd99999999;
    localparam logic [NUM_BITS-1:0] LIMIT_QWORD = 64'd9999999999999999;

    // One word as it travels down the cell chain.
    typedef struct packed {
        logic                  valid;
        logic                  mode;
        t_size                 size;
        logic                  ovf;
        logic [NUM_BITS-1:0]   value;
        logic [NUM_BITS-1:0]   acc;
        logic [DIGIT_BITS-2:0] dig;
    } t_stage;

    function automatic logic [NUM_BITS-1:0] size_mask(input t_size sz);
        logic [NUM_BITS-1:0] m;
        unique case (sz)
            SIZE_BYTE:  m = 64'h0000_0000_0000_00FF;
            SIZE_WORD:  m = 64'h0000_0000_0000_FFFF;
            SIZE_DWORD: m = 64'h0000_0000_FFFF_FFFF;
            SIZE_QWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [NUM_BITS-1:0] size_limit(input t_size sz);
        logic [NUM_BITS-1:0] l;
        unique case (sz)
            SIZE_BYTE:  l = LIMIT_BYTE;
            SIZE_WORD:  l = LIMIT_WORD;
            SIZE_DWORD: l = LIMIT_DWORD;
            SIZE_QWORD: l = LIMIT_QWORD;
        endcase
        return l;
    endfunction

    // Add three to every BCD digit of five or more, ahead of a left shift.
    function automatic logic [NUM_BITS-1:0] add3(input logic [NUM_BITS-1:0] bcd);
        logic [NUM_BITS-1:0] r;
        r = bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                r[d*DIGIT_BITS +: DIGIT_BITS] = bcd[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/bcdc_ifs.sv =====
// Handshake interfaces for the converter's input and output words.
// Depend on nothing but plain logic types.
interface bcdc_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [1:0]  size;
    logic [63:0] value;

    modport source (output valid, output mode, output size, output value, input ready);
    modport sink   (input valid, input mode, input size, input value, output ready);
endinterface

interface bcdc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic        overflow;

    modport source (output valid, output result, output overflow, input ready);
    modport sink   (input valid, input result, input overflow, output ready);
endinterface

// ===== rtl/bcdc_cell.sv =====
// One cell of the conversion chain: takes one operand bit per cycle while enabled.
// Depends on bcdc_pkg.
module bcdc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_digit_end,
    input  bcdc_pkg::t_stage i_stage,
    output bcdc_pkg::t_stage o_stage
);
    import bcdc_pkg::*;

    t_stage              r_stage;
    t_stage              n_stage;
    logic                w_bit;
    logic [NUM_BITS-1:0] w_fixed;

    assign w_bit   = i_stage.value[NUM_BITS-1];
    assign w_fixed = add3(i_stage.acc);

    // Shift the operand left and fold its top bit into the accumulator.
    always_comb begin
        n_stage       = i_stage;
        n_stage.value = {i_stage.value[NUM_BITS-2:0], 1'b0};
        if (i_stage.mode == MODE_BIN2BCD) begin
            // Double dabble step: correct the digits, then shift the bit in.
            n_stage.acc = {w_fixed[NUM_BITS-2:0], w_bit};
        end else if (i_digit_end) begin
            // Last bit of a nibble: acc = acc * 10 + digit.
            n_stage.acc = (i_stage.acc << 3) + (i_stage.acc << 1)
                        + {{(NUM_BITS-DIGIT_BITS){1'b0}}, i_stage.dig, w_bit};
            n_stage.dig = '0;
        end else begin
            n_stage.dig = {i_stage.dig[DIGIT_BITS-3:0], w_bit};
        end
    end

    // Only the valid flag is reset; the payload follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/bcdc_out.sv =====
// Output register with a one-word skid stage behind it.
// Depends on bcdc_pkg and the bcdc_out_if interface.
module bcdc_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcdc_pkg::t_stage  i_stage,
    output logic              o_en,
    bcdc_out_if.source        o_out
);
    import bcdc_pkg::*;

    logic                r_out_valid, n_out_valid;
    logic [NUM_BITS-1:0] r_out_res,   n_out_res;
    logic                r_out_ovf,   n_out_ovf;
    logic                r_skid_valid, n_skid_valid;
    logic [NUM_BITS-1:0] r_skid_res,  n_skid_res;
    logic                r_skid_ovf,  n_skid_ovf;
    logic [NUM_BITS-1:0] w_res;
    logic                w_take;
    logic                w_new;

    // Final result: zero on overflow, else the accumulator at the chosen size.
    assign w_res  = i_stage.ovf ? '0 : (i_stage.acc & size_mask(i_stage.size));
    assign w_take = r_out_valid && o_out.ready;
    assign w_new  = i_stage.valid && !r_skid_valid;

    // Route the arriving word to the output register or the skid stage.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_res    = r_out_res;
        n_out_ovf    = r_out_ovf;
        n_skid_valid = r_skid_valid;
        n_skid_res   = r_skid_res;
        n_skid_ovf   = r_skid_ovf;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_res    = r_skid_res;
                n_out_ovf    = r_skid_ovf;
                n_skid_valid = 1'b0;
            end
        end else if (w_new) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_res   = w_res;
                n_out_ovf   = i_stage.ovf;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_res   = w_res;
                n_skid_ovf   = i_stage.ovf;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_res  <= n_out_res;
        r_out_ovf  <= n_out_ovf;
        r_skid_res <= n_skid_res;
        r_skid_ovf <= n_skid_ovf;
    end

    // The chain moves whenever the skid stage has room.
    assign o_en           = !r_skid_valid;
    assign o_out.valid    = r_out_valid;
    assign o_out.result   = r_out_res;
    assign o_out.overflow = r_out_ovf;

endmodule

// ===== rtl/bcd_binary_converter.sv =====
// Top level of the BCD/binary converter: input register, cell chain, output stage.
// Depends on bcdc_pkg, bcdc_ifs, bcdc_cell and bcdc_out.

// Converts packed BCD to binary (mode 0) or binary to packed BCD (mode 1) at
// byte, word, double word or quad word size. The operand is masked to the
// size; BCD nibbles above nine are weighted like valid digits, and a binary
// value beyond the decimal digits of the size returns zero with overflow set.
// The converter takes one word per clock cycle while input ready is high and
// passes each accepted word through one input register, a chain of 64 cells that
// each take one operand bit (add-3 double dabble for binary to BCD, a
// times-ten accumulate at every fourth cell for BCD to binary), and an
// output register. A skid stage keeps input ready high while a single result
// waits on the output; input ready drops only once the skid stage also holds
// a word.
module bcd_binary_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcdc_in_if.sink    i_in,
    bcdc_out_if.source o_out
);
    import bcdc_pkg::*;

    t_stage              r_in, n_in;
    t_stage              w_chain [NUM_CELLS+1];
    logic                w_en;
    logic [NUM_BITS-1:0] w_masked;

    assign i_in.ready = w_en;

    // Mask the operand and check the decimal range on entry.
    always_comb begin
        w_masked    = i_in.value & size_mask(t_size'(i_in.size));
        n_in.valid  = i_in.valid;
        n_in.mode   = i_in.mode;
        n_in.size   = t_size'(i_in.size);
        n_in.value  = w_masked;
        n_in.ovf    = (i_in.mode == MODE_BIN2BCD)
                    && (w_masked > size_limit(t_size'(i_in.size)));
        n_in.acc    = '0;
        n_in.dig    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    assign w_chain[0] = r_in;

    // The chain of bit cells; every fourth one closes a BCD digit.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        bcdc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_digit_end ((k % DIGIT_BITS) == (DIGIT_BITS - 1)),
            .i_stage     (w_chain[k]),
            .o_stage     (w_chain[k+1])
        );
    end

    bcdc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_chain[NUM_CELLS]),
        .o_en    (w_en),
        .o_out   (o_out)
    );

    // A full skid stage means the output register is also holding a word.
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> o_out.valid)
        else $error("skid stage full while output register is empty");

    // An overflowed result is always zero.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> (o_out.result == '0))
        else $error("overflow with a nonzero result");

    // Overflow can only be raised for binary to BCD conversions.
    a_ovf_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in.valid && r_in.ovf) |-> (r_in.mode == MODE_BIN2BCD))
        else $error("overflow flagged in BCD to binary mode");

    // While the chain is stalled its last cell holds its word.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && !$past(!i_rst_n)) |=> $stable(w_chain[NUM_CELLS]))
        else $error("chain moved while stalled");

endmodule
